// ----- hdl/html_entity_decoder_unit_defines.svh -----
// Assertion macros shared by the checker files of the entity decoder.
// No dependencies; include by bare file name.
`ifndef HTML_ENTITY_DECODER_UNIT_DEFINES_SVH
`define HTML_ENTITY_DECODER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define HED_ASSERT_NOW(lbl, c, r, ante, cons) \
  lbl: assert property (@(posedge c) disable iff (!r) (ante) |-> (cons)) \
    else $error("hed: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted
`define HED_ASSERT_NEXT(lbl, c, r, ante, cons) \
  lbl: assert property (@(posedge c) disable iff (!r) (ante) |=> (cons)) \
    else $error("hed: next-cycle check failed");

// Next-cycle implication that stays live through reset
`define HED_ASSERT_ALWAYS(lbl, c, ante, cons) \
  lbl: assert property (@(posedge c) (ante) |=> (cons)) \
    else $error("hed: reset-time check failed");

`endif

// ----- hdl/hed_pkg.sv -----
// Shared types and character constants of the entity decoder.
// No dependencies.
package hed_pkg;

  localparam int HoldDepth = 5;
  localparam int BurstMax  = HoldDepth + 1;

  typedef logic [7:0] char_t;
  // held byte count, 0..HoldDepth
  typedef logic [$clog2(HoldDepth+1)-1:0] cnt_t;
  // beats in one burst, 0..BurstMax
  typedef logic [$clog2(BurstMax+1)-1:0] blen_t;

  localparam char_t ChAmp  = 8'h26;
  localparam char_t ChSemi = 8'h3b;
  localparam char_t ChLt   = 8'h3c;
  localparam char_t ChGt   = 8'h3e;
  localparam char_t ChQuot = 8'h22;
  localparam char_t ChApos = 8'h27;

  // One item's results, oldest in entry 0
  typedef struct packed {
    logic [BurstMax-1:0][7:0] chars;
    blen_t                    len;
    logic                     text_end;
  } burst_t;

endpackage

// ----- hdl/hed_in_if.sv -----
// Input byte channel of the entity decoder: valid/ready plus payload.
// Depends on hed_pkg.
interface hed_in_if import hed_pkg::*; ();
  logic  valid;
  logic  ready;
  char_t in_byte;
  logic  is_last;

  modport source (output valid, in_byte, is_last, input ready);
  modport sink   (input valid, in_byte, is_last, output ready);
endinterface

// ----- hdl/hed_out_if.sv -----
// Result byte channel of the entity decoder: valid/ready plus payload.
// Depends on hed_pkg.
interface hed_out_if import hed_pkg::*; ();
  logic  valid;
  logic  ready;
  char_t out_byte;
  logic  run_last;
  logic  text_end;

  modport source (output valid, out_byte, run_last, text_end, input ready);
  modport sink   (input valid, out_byte, run_last, text_end, output ready);
endinterface

// ----- hdl/hed_match.sv -----
// Entity name matcher: compares the held run against the five known names.
// Depends on hed_pkg.
module hed_match import hed_pkg::*; (
  input  char_t [HoldDepth-1:1] name_chars,
  input  cnt_t                  cnt,
  output logic                  hit,
  output char_t                 dec_char
);

  function automatic char_t to_lower(char_t c);
    if (c >= 8'h41 && c <= 8'h5a) begin
      return c + 8'd32;
    end
    return c;
  endfunction

  char_t l1, l2, l3, l4;

  // Fold ASCII upper case
  assign l1 = to_lower(name_chars[1]);
  assign l2 = to_lower(name_chars[2]);
  assign l3 = to_lower(name_chars[3]);
  assign l4 = to_lower(name_chars[4]);

  // Run length includes the leading ampersand
  always_comb begin
    hit      = 1'b1;
    dec_char = ChAmp;
    if (cnt == cnt_t'(4) && {l1, l2, l3} == "amp") begin
      dec_char = ChAmp;
    end else if (cnt == cnt_t'(3) && {l1, l2} == "lt") begin
      dec_char = ChLt;
    end else if (cnt == cnt_t'(3) && {l1, l2} == "gt") begin
      dec_char = ChGt;
    end else if (cnt == cnt_t'(5) && {l1, l2, l3, l4} == "quot") begin
      dec_char = ChQuot;
    end else if (cnt == cnt_t'(5) && {l1, l2, l3, l4} == "apos") begin
      dec_char = ChApos;
    end else begin
      hit = 1'b0;
    end
  end

endmodule

// ----- hdl/hed_core.sv -----
// Input register, held run and burst formation of the entity decoder.
// Depends on hed_pkg, hed_in_if and hed_match.
module hed_core import hed_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  hed_in_if.sink    in_ch,
  input  logic      buf_free,
  output logic      burst_vld,
  output burst_t    burst
);

  logic                  in_vld_r;
  char_t                 byte_r;
  logic                  last_r;
  char_t [HoldDepth-1:0] held_r;
  cnt_t                  cnt_r;
  cnt_t                  cnt_nxt;

  logic  hit;
  char_t dec_char;
  logic  advance;
  logic  is_amp, is_semi;
  cnt_t  rel;
  logic  tail_en;
  char_t tail;
  logic  wr_en;
  cnt_t  wr_idx;

  hed_match u_match (
    .name_chars (held_r[HoldDepth-1:1]),
    .cnt        (cnt_r),
    .hit        (hit),
    .dec_char   (dec_char)
  );

  // Decide what the registered beat releases and what it holds
  always_comb begin
    is_amp  = (byte_r == ChAmp);
    is_semi = (byte_r == ChSemi);
    rel     = '0;
    tail_en = 1'b0;
    tail    = byte_r;
    wr_en   = 1'b0;
    wr_idx  = cnt_r;
    cnt_nxt = cnt_r;
    if (cnt_r == '0) begin
      if (is_amp) begin
        wr_en   = 1'b1;
        wr_idx  = '0;
        cnt_nxt = cnt_t'(1);
        if (last_r) begin
          tail_en = 1'b1;
          cnt_nxt = '0;
        end
      end else begin
        tail_en = 1'b1;
      end
    end else if (is_semi) begin
      cnt_nxt = '0;
      tail_en = 1'b1;
      if (hit) begin
        tail = dec_char;
      end else begin
        rel = cnt_r;
      end
    end else if (is_amp) begin
      rel     = cnt_r;
      wr_en   = 1'b1;
      wr_idx  = '0;
      cnt_nxt = cnt_t'(1);
      if (last_r) begin
        tail_en = 1'b1;
        cnt_nxt = '0;
      end
    end else if (cnt_r == cnt_t'(HoldDepth)) begin
      rel     = cnt_r;
      tail_en = 1'b1;
      cnt_nxt = '0;
    end else begin
      wr_en   = 1'b1;
      cnt_nxt = cnt_r + cnt_t'(1);
      if (last_r) begin
        rel     = cnt_r;
        tail_en = 1'b1;
        cnt_nxt = '0;
      end
    end
  end

  // Lay out the burst: released held bytes, then the tail byte
  always_comb begin
    for (int k = 0; k < HoldDepth; k++) begin
      burst.chars[k] = (cnt_t'(k) < rel) ? held_r[k] : tail;
    end
    burst.chars[HoldDepth] = tail;
    burst.len              = blen_t'(rel) + blen_t'(tail_en);
    burst.text_end         = last_r;
  end

  // Advance when the burst is empty or the output buffer takes it
  assign burst_vld   = in_vld_r && (burst.len != '0);
  assign advance     = in_vld_r && ((burst.len == '0) || buf_free);
  assign in_ch.ready = !in_vld_r || advance;

  // Hold the accepted beat and the run state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      if (in_ch.ready) begin
        in_vld_r <= in_ch.valid;
      end
      if (advance) begin
        cnt_r <= cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      byte_r <= in_ch.in_byte;
      last_r <= in_ch.is_last;
    end
    if (advance && wr_en) begin
      held_r[wr_idx] <= byte_r;
    end
  end

endmodule

// ----- hdl/hed_serial.sv -----
// Output burst buffer: shifts one item's results out a beat at a time.
// Depends on hed_pkg and hed_out_if.
module hed_serial import hed_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      burst_vld,
  input  burst_t    burst,
  output logic      buf_free,
  hed_out_if.source out_ch
);

  logic [BurstMax-1:0][7:0] chars_r;
  blen_t                    left_r;
  logic                     end_r;
  logic                     beat;
  logic                     load;

  assign out_ch.valid    = (left_r != '0);
  assign out_ch.out_byte = chars_r[0];
  assign out_ch.run_last = (left_r == blen_t'(1));
  assign out_ch.text_end = end_r && (left_r == blen_t'(1));

  assign beat     = out_ch.valid && out_ch.ready;
  assign buf_free = (left_r == '0) || (beat && left_r == blen_t'(1));
  assign load     = burst_vld && buf_free;

  // Count remaining beats
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r <= '0;
    end else if (load) begin
      left_r <= burst.len;
    end else if (beat) begin
      left_r <= left_r - blen_t'(1);
    end
  end

  // Load a new burst or advance the shift line
  always_ff @(posedge clk) begin
    if (load) begin
      chars_r <= burst.chars;
      end_r   <= burst.text_end;
    end else if (beat) begin
      chars_r <= {8'h00, chars_r[BurstMax-1:1]};
    end
  end

endmodule

// ----- hdl/html_entity_decoder_unit.sv -----
// HTML entity decoder top level: input register, held run and output burst buffer.
// Depends on hed_pkg, hed_in_if, hed_out_if, hed_core and hed_serial.
//
// Takes text a byte per beat and decodes &amp; &lt; &gt; &quot; &apos; (name
// letters in either case); every other byte passes through in order. A beat
// is registered, then its results (zero to six bytes) are formed and loaded into
// the output buffer once it is free, which then offers the first result. Input
// beats are taken every cycle while each causes at most one result and out
// ready stays high; a beat that gives more results holds the output buffer until
// all are shifted out, and a following beat with results waits for it (longer
// under out ready low). The output buffer shifts out one beat per cycle under
// out ready.
module html_entity_decoder_unit import hed_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  hed_in_if.sink    in_ch,
  hed_out_if.source out_ch
);

  logic   buf_free;
  logic   burst_vld;
  burst_t burst;

  hed_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .buf_free  (buf_free),
    .burst_vld (burst_vld),
    .burst     (burst)
  );

  hed_serial u_serial (
    .clk       (clk),
    .rst_n     (rst_n),
    .burst_vld (burst_vld),
    .burst     (burst),
    .buf_free  (buf_free),
    .out_ch    (out_ch)
  );

endmodule

// ----- hdl/hed_checker.sv -----
// Port-level checks of the entity decoder, bound to the top level.
// Depends on hed_in_if, hed_out_if and the assertion macro header.
`include "html_entity_decoder_unit_defines.svh"

module hed_checker (
  input logic       clk,
  input logic       rst_n,
  hed_in_if.sink    in_ch,
  hed_out_if.source out_ch
);

  logic       out_stall;
  logic [9:0] out_word;

  // Gather the result payload and the stalled condition
  assign out_stall = out_ch.valid && !out_ch.ready;
  assign out_word  = {out_ch.out_byte, out_ch.run_last, out_ch.text_end};

  // No result beat right after a reset cycle
  `HED_ASSERT_ALWAYS(a_quiet_after_reset, clk, !rst_n, !out_ch.valid)

  // The end of the text is always the last beat of its item
  `HED_ASSERT_NOW(a_end_is_run_last, clk, rst_n, out_ch.valid && out_ch.text_end, out_ch.run_last)

  // An empty output side never blocks input
  `HED_ASSERT_NOW(a_ready_when_drained, clk, rst_n, !out_ch.valid, in_ch.ready)

  // A stalled result beat holds
  `HED_ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, out_ch.valid && $stable(out_word))

endmodule

bind html_entity_decoder_unit hed_checker u_hed_checker (
  .clk    (clk),
  .rst_n  (rst_n),
  .in_ch  (in_ch),
  .out_ch (out_ch)
);

// ----- sim/html_entity_decoder_unit_tb.sv -----
// Self-checking bench for html_entity_decoder_unit: random and directed text in,
// decoded bytes checked against an in-bench model of the entity decoder.
// Depends on hed_pkg, hed_in_if, hed_out_if and the decoder RTL.
`timescale 1ns / 1ps

module html_entity_decoder_unit_tb;
  import hed_pkg::*;

  localparam int   RandomBeats = 410;
  localparam int   CycleLimit  = 200000;
  localparam int   LongStallAt = 120;
  localparam int   LongStall   = 300;
  localparam int   DrainCycles = 20;
  localparam logic [7:0] UpperA = 8'h41;
  localparam logic [7:0] UpperZ = 8'h5a;
  localparam logic [7:0] LowerA = 8'h61;
  localparam logic [7:0] LowerZ = 8'h7a;
  localparam logic [7:0] CaseBit = 8'h20;

  typedef struct {
    char_t data;
    logic  last;
  } text_beat_t;

  typedef struct {
    char_t ch;
    logic  run_last;
    logic  text_end;
  } decoded_beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  hed_in_if  in_ch ();
  hed_out_if out_ch ();

  html_entity_decoder_unit u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  text_beat_t    pend_q[$];
  decoded_beat_t decoded_q[$];
  char_t         run_buf[HoldDepth];
  int            run_len = 0;
  int            errs = 0;
  int            cycles = 0;
  int            in_gap = 0;
  int            out_hold = 0;
  int            out_beats = 0;
  bit            rush_in = 1'b0;
  bit            rush_out = 1'b0;
  string         ent_name[5] = '{"amp", "lt", "gt", "quot", "apos"};

  always #1 clk = ~clk;

  // Known values on every block input before the first edge
  initial begin
    in_ch.valid   = 1'b0;
    in_ch.in_byte = '0;
    in_ch.is_last = 1'b0;
    out_ch.ready  = 1'b0;
  end

  // Mirror one accepted text byte and queue the bytes it should produce
  function automatic void decode_text_byte(char_t b, logic last);
    char_t       res[$];
    logic [31:0] name;
    char_t       c;
    int          hit;
    name = '0;
    hit  = -1;
    if (run_len == 0) begin
      if (b == ChAmp) begin
        run_buf[0] = b;
        run_len = 1;
      end else begin
        res.push_back(b);
      end
    end else if (b == ChSemi) begin
      for (int i = 1; i < run_len; i++) begin
        c = run_buf[i];
        if (c >= UpperA && c <= UpperZ) c = c | CaseBit;
        name = {name[23:0], c};
      end
      case (run_len)
        3: begin
          if (name[15:0] == "lt") hit = ChLt;
          else if (name[15:0] == "gt") hit = ChGt;
        end
        4: if (name[23:0] == "amp") hit = ChAmp;
        5: begin
          if (name == "quot") hit = ChQuot;
          else if (name == "apos") hit = ChApos;
        end
        default: hit = -1;
      endcase
      if (hit >= 0) begin
        res.push_back(char_t'(hit));
      end else begin
        for (int i = 0; i < run_len; i++) res.push_back(run_buf[i]);
        res.push_back(b);
      end
      run_len = 0;
    end else if (b == ChAmp) begin
      for (int i = 0; i < run_len; i++) res.push_back(run_buf[i]);
      run_buf[0] = b;
      run_len = 1;
    end else if (run_len >= HoldDepth) begin
      for (int i = 0; i < run_len; i++) res.push_back(run_buf[i]);
      res.push_back(b);
      run_len = 0;
    end else begin
      run_buf[run_len] = b;
      run_len++;
    end
    // flush whatever is still held at end of text
    if (last) begin
      for (int i = 0; i < run_len; i++) res.push_back(run_buf[i]);
      run_len = 0;
    end
    foreach (res[i]) begin
      decoded_q.push_back('{ch: res[i],
                             run_last: (i == res.size() - 1),
                             text_end: last && (i == res.size() - 1)});
    end
  endfunction

  task automatic note_mismatch(string what);
    $display("cycle %0d: %s", cycles, what);
    errs++;
  endtask

  task automatic push_beat(char_t d, logic l);
    pend_q.push_back('{data: d, last: l});
  endtask

  task automatic push_text(string s, logic last_on_end);
    for (int i = 0; i < s.len(); i++) begin
      push_beat(char_t'(s[i]), last_on_end && (i == s.len() - 1));
    end
  endtask

  // Push '&', the first keep letters of the name with random letter case, and optionally the ';'
  task automatic push_entity(int k, int keep, bit close);
    char_t c;
    push_beat(ChAmp, 1'b0);
    for (int i = 0; i < keep; i++) begin
      c = char_t'(ent_name[k][i]);
      if (c >= LowerA && c <= LowerZ && $urandom_range(0, 1)) c = c ^ CaseBit;
      push_beat(c, 1'b0);
    end
    if (close) push_beat(ChSemi, 1'b0);
  endtask

  // Sender: hold a beat until taken, then idle a drawn number of cycles
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_ch.valid) begin
        pend_q.delete(0);
        if ($urandom_range(0, 39) == 0) rush_in = ~rush_in;
        in_gap = rush_in ? 0 : $urandom_range(0, 4);
      end
      if (in_gap > 0) begin
        in_gap--;
        in_ch.valid <= 1'b0;
      end else if (pend_q.size() != 0) begin
        in_ch.valid   <= 1'b1;
        in_ch.in_byte <= pend_q[0].data;
        in_ch.is_last <= pend_q[0].last;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver: drop ready for a drawn number of cycles after each beat,
  // once for a long stretch so the block backs up into its input
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        out_beats++;
        if ($urandom_range(0, 39) == 0) rush_out = ~rush_out;
        if (out_beats == LongStallAt) out_hold = LongStall;
        else out_hold = rush_out ? 0 : $urandom_range(0, 4);
      end
      if (out_hold > 0) begin
        out_hold--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Monitor: predict on each input beat, then check each output beat
  always @(posedge clk) begin
    decoded_beat_t want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) decode_text_byte(in_ch.in_byte, in_ch.is_last);
      if (out_ch.valid && out_ch.ready) begin
        if (decoded_q.size() == 0) begin
          note_mismatch($sformatf("unexpected byte %h", out_ch.out_byte));
        end else begin
          want = decoded_q.pop_front();
          if (out_ch.out_byte !== want.ch)
            note_mismatch($sformatf("out_byte %h, want %h", out_ch.out_byte, want.ch));
          if (out_ch.run_last !== want.run_last)
            note_mismatch($sformatf("run_last %b, want %b (byte %h)",
                                    out_ch.run_last, want.run_last, want.ch));
          if (out_ch.text_end !== want.text_end)
            note_mismatch($sformatf("text_end %b, want %b (byte %h)",
                                    out_ch.text_end, want.text_end, want.ch));
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int target;
    int k;
    int n;
    // directed: plain bytes, new ampersand, decoded ampersand not rescanned,
    // mixed case, unknown name, overlong run, lone ampersand at end of text
    push_beat(8'h00, 1'b0);
    push_text("&&amp;lt;", 1'b0);
    push_text("&QuOt;", 1'b0);
    push_text("&x;", 1'b0);
    push_text("&abcd", 1'b0);
    push_beat(8'hff, 1'b0);
    push_text("&", 1'b1);
    target = pend_q.size() + RandomBeats;

    // random: mostly entity-shaped runs, plus noise and broken runs
    while (pend_q.size() < target) begin
      k = $urandom_range(0, 4);
      case ($urandom_range(0, 9))
        0, 1: push_beat(char_t'($urandom_range(8'h20, 8'h7e)), 1'b0);
        2:    push_beat(char_t'($urandom_range(0, 255)), 1'b0);
        3, 4, 5: push_entity(k, ent_name[k].len(), 1'b1);
        6: begin
          push_entity(k, $urandom_range(0, ent_name[k].len()), 1'b0);
          n = $urandom_range(0, 2);
          if (n == 1) push_beat(ChAmp, 1'b0);
          else if (n == 2) push_beat(char_t'($urandom_range(0, 255)), 1'b0);
        end
        7: begin
          push_beat(ChAmp, 1'b0);
          n = $urandom_range(0, 4);
          for (int i = 0; i < n; i++) push_beat(char_t'($urandom_range(0, 255)), 1'b0);
          push_beat(ChSemi, 1'b0);
        end
        8: begin
          push_beat(ChAmp, 1'b0);
          n = $urandom_range(4, 6);
          for (int i = 0; i < n; i++)
            push_beat(char_t'($urandom_range(LowerA, LowerZ)), 1'b0);
        end
        default: begin
          push_entity(0, 3, 1'b1);
          push_text(ent_name[k], 1'b0);
          push_beat(ChSemi, 1'b0);
        end
      endcase
      // close the text here now and then, often with a run still held
      if ($urandom_range(0, 9) == 0) pend_q[pend_q.size() - 1].last = 1'b1;
    end
    pend_q[pend_q.size() - 1].last = 1'b1;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (pend_q.size() != 0) @(posedge clk);
    @(posedge clk);
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (errs == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
